// File: design/environment_climate_controller_defines.svh
// Assertion macros for the environment climate controller.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef ENVIRONMENT_CLIMATE_CONTROLLER_DEFINES_SVH
`define ENVIRONMENT_CLIMATE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, off during reset
`define ECC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ecc_pkg.sv
// Shared types, register codes and constants for the environment climate controller.
// No dependencies.
package ecc_pkg;

  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HEAT_ON_BELOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEAT_OFF_ABOVE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAS_LIMIT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAS_DELAY_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_STEP      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_RAMP_START  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HUM_FULL        = 3'd6;

  // Reset values of the configuration registers
  localparam logic [8:0] HEAT_ON_BELOW_RST   = 9'd35;
  localparam logic [8:0] HEAT_OFF_ABOVE_RST  = 9'd37;
  localparam logic [9:0] GAS_LIMIT_RST       = 10'd400;
  localparam logic [7:0] GAS_DELAY_TICKS_RST = 8'd15;
  localparam logic [7:0] LIGHT_STEP_RST      = 8'd200;
  localparam logic [6:0] HUM_RAMP_START_RST  = 7'd44;
  localparam logic [6:0] HUM_FULL_RST        = 7'd47;

  // t*500/1023 as t * (500*ceil(2^29/1023)) >> 29, exact for 10-bit t
  localparam int unsigned DegShift = 29;
  localparam logic [27:0] DEG_MULT = 28'd262400500;

  localparam logic [6:0]  HUM_SCALE     = 7'd100;
  localparam logic [16:0] HUM_DIV       = 17'd65535;
  localparam logic [15:0] HUM_RAW_FULL  = 16'hFFFF;
  localparam logic [6:0]  HUM_DEFAULT   = 7'd40;
  localparam logic [8:0]  RAMP_STEP     = 9'd341;
  localparam logic [9:0]  DUTY_FULL     = 10'd1023;

  typedef struct packed {
    logic [8:0] heat_on_below;
    logic [8:0] heat_off_above;
    logic [9:0] gas_limit;
    logic [7:0] gas_delay_ticks;
    logic [7:0] light_step;
    logic [6:0] hum_ramp_start;
    logic [6:0] hum_full;
  } cfg_t;

  typedef struct packed {
    logic [8:0] temp_degrees;
    logic [6:0] hum_percent;
    logic [3:0] light_bars;
    logic [9:0] hum_duty;
    logic       air_bad;
  } calc_t;

endpackage

// File: design/ecc_calc.sv
// Stateless per-tick conversions: degrees, humidity percent, light bars, humidity fan duty.
// Depends on ecc_pkg.
module ecc_calc (
  input  logic [9:0]     temp_sample,
  input  logic [9:0]     light_sample,
  input  logic [9:0]     gas_sample,
  input  logic [15:0]    hum_raw,
  input  ecc_pkg::cfg_t  cfg,
  output ecc_pkg::calc_t res
);

  logic [37:0] deg_prod;
  logic [22:0] hum_prod;
  logic [6:0]  hum_q0;
  logic [16:0] hum_rem;
  logic [6:0]  pct;
  logic [9:0]  step1;
  logic [9:0]  step2;
  logic [9:0]  step3;
  logic [9:0]  step4;
  logic [6:0]  ramp_diff;
  logic [15:0] ramp_prod;

  assign deg_prod = 38'(temp_sample) * 38'(ecc_pkg::DEG_MULT);

  // h*100/65535: take the /65536 quotient, then correct once on the remainder
  assign hum_prod = 23'(hum_raw) * 23'(ecc_pkg::HUM_SCALE);
  assign hum_q0   = hum_prod[22:16];
  assign hum_rem  = 17'(hum_prod[15:0]) + 17'(hum_q0);

  always_comb begin
    if (hum_raw == '0 || hum_raw == ecc_pkg::HUM_RAW_FULL) begin
      pct = ecc_pkg::HUM_DEFAULT;
    end else if (hum_rem >= ecc_pkg::HUM_DIV) begin
      pct = hum_q0 + 7'd1;
    end else begin
      pct = hum_q0;
    end
  end

  assign step1 = 10'(cfg.light_step);
  assign step2 = {1'b0, cfg.light_step, 1'b0};
  assign step3 = step2 + step1;
  assign step4 = {cfg.light_step, 2'b00};

  assign ramp_diff = pct - cfg.hum_ramp_start;
  assign ramp_prod = 16'(ramp_diff) * 16'(ecc_pkg::RAMP_STEP);

  always_comb begin
    res.temp_degrees  = deg_prod[ecc_pkg::DegShift +: 9];
    res.hum_percent   = pct;
    res.light_bars[3] = light_sample < step1;
    res.light_bars[2] = light_sample < step2;
    res.light_bars[1] = light_sample < step3;
    res.light_bars[0] = light_sample < step4;
    res.air_bad       = gas_sample > cfg.gas_limit;
    priority if (pct > cfg.hum_full) begin
      res.hum_duty = ecc_pkg::DUTY_FULL;
    end else if (pct > cfg.hum_ramp_start) begin
      res.hum_duty = (ramp_prod > 16'(ecc_pkg::DUTY_FULL)) ? ecc_pkg::DUTY_FULL
                                                            : ramp_prod[9:0];
    end else begin
      res.hum_duty = '0;
    end
  end

endmodule

// File: design/environment_climate_controller.sv
// Top level of the environment climate controller: config registers, input and result
// registers, and tick state. Depends on ecc_pkg, ecc_calc and the defines header.
//
//  channel | signals                               | direction
//  in      | in_valid, in_stall, four sample ports | sensor tick into the block
//  out     | out_valid, out_stall, eight result    | one result item per tick
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | register writes, always ready
//
// One item per cycle while out_stall is low; an accepted item passes through the input register
// and then the result register. The path from input register to result register holds the
// constant multiplies for degrees and humidity, the fan ramp multiply and the compares.
// Reset restores the register defaults and clears heater, gas count, alarm and blink.
// out_stall holds the result register; in_stall rises only while both registers are full
// and the result is stalled.
`include "environment_climate_controller_defines.svh"

module environment_climate_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  temp_sample,
  input  logic [9:0]  light_sample,
  input  logic [9:0]  gas_sample,
  input  logic [15:0] hum_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        heater_on,
  output logic [3:0]  light_bars,
  output logic [9:0]  fan_duty,
  output logic        air_bad,
  output logic        alarm_active,
  output logic        alarm_led,
  output logic [8:0]  temp_degrees,
  output logic [6:0]  hum_percent,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ecc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [9:0]  cfg_data
);

  ecc_pkg::cfg_t  cfg;
  ecc_pkg::calc_t calc;

  logic        stage_valid;
  logic [9:0]  stage_temp;
  logic [9:0]  stage_light;
  logic [9:0]  stage_gas;
  logic [15:0] stage_hum;

  logic        heater_state;
  logic [7:0]  gas_count;
  logic        alarm_flag;
  logic        blink_phase;

  logic        heater_state_next;
  logic [7:0]  gas_count_next;
  logic        alarm_flag_next;

  logic        in_take;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = stage_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_on_below   <= ecc_pkg::HEAT_ON_BELOW_RST;
      cfg.heat_off_above  <= ecc_pkg::HEAT_OFF_ABOVE_RST;
      cfg.gas_limit       <= ecc_pkg::GAS_LIMIT_RST;
      cfg.gas_delay_ticks <= ecc_pkg::GAS_DELAY_TICKS_RST;
      cfg.light_step      <= ecc_pkg::LIGHT_STEP_RST;
      cfg.hum_ramp_start  <= ecc_pkg::HUM_RAMP_START_RST;
      cfg.hum_full        <= ecc_pkg::HUM_FULL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ecc_pkg::REG_HEAT_ON_BELOW:   cfg.heat_on_below   <= cfg_data[8:0];
        ecc_pkg::REG_HEAT_OFF_ABOVE:  cfg.heat_off_above  <= cfg_data[8:0];
        ecc_pkg::REG_GAS_LIMIT:       cfg.gas_limit       <= cfg_data;
        ecc_pkg::REG_GAS_DELAY_TICKS: cfg.gas_delay_ticks <= cfg_data[7:0];
        ecc_pkg::REG_LIGHT_STEP:      cfg.light_step      <= cfg_data[7:0];
        ecc_pkg::REG_HUM_RAMP_START:  cfg.hum_ramp_start  <= cfg_data[6:0];
        ecc_pkg::REG_HUM_FULL:        cfg.hum_full        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_temp  <= temp_sample;
      stage_light <= light_sample;
      stage_gas   <= gas_sample;
      stage_hum   <= hum_raw;
    end
  end

  ecc_calc u_calc (
    .temp_sample  (stage_temp),
    .light_sample (stage_light),
    .gas_sample   (stage_gas),
    .hum_raw      (stage_hum),
    .cfg          (cfg),
    .res          (calc)
  );

  always_comb begin
    priority if (calc.temp_degrees < cfg.heat_on_below) begin
      heater_state_next = 1'b1;
    end else if (calc.temp_degrees > cfg.heat_off_above) begin
      heater_state_next = 1'b0;
    end else begin
      heater_state_next = heater_state;
    end

    gas_count_next  = gas_count;
    alarm_flag_next = alarm_flag;
    if (calc.air_bad) begin
      if (gas_count < cfg.gas_delay_ticks) begin
        gas_count_next = gas_count + 8'd1;
      end else begin
        alarm_flag_next = 1'b1;
      end
    end else begin
      gas_count_next  = '0;
      alarm_flag_next = 1'b0;
    end
  end

  // Tick state advances when the staged item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      heater_state <= 1'b0;
      gas_count    <= '0;
      alarm_flag   <= 1'b0;
      blink_phase  <= 1'b0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
      if (stage_valid) begin
        heater_state <= heater_state_next;
        gas_count    <= gas_count_next;
        alarm_flag   <= alarm_flag_next;
        blink_phase  <= !blink_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      heater_on    <= heater_state_next;
      light_bars   <= calc.light_bars;
      fan_duty     <= calc.air_bad ? ecc_pkg::DUTY_FULL : calc.hum_duty;
      air_bad      <= calc.air_bad;
      alarm_active <= alarm_flag_next;
      alarm_led    <= alarm_flag_next && blink_phase;
      temp_degrees <= calc.temp_degrees;
      hum_percent  <= calc.hum_percent;
    end
  end

  `ECC_ASSERT_NOW(a_alarm_bad_air, out_valid && alarm_active, air_bad, "alarm on good air")
  `ECC_ASSERT_NOW(a_led_alarm, out_valid && alarm_led, alarm_active, "lamp lit, alarm off")
  `ECC_ASSERT_NOW(a_fan_full, out_valid && air_bad, fan_duty == ecc_pkg::DUTY_FULL, "fan low")
  `ECC_ASSERT_NEXT(a_blink, advance && stage_valid, blink_phase != $past(blink_phase), "no blink")

endmodule

// File: verif/tb_environment_climate_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for environment_climate_controller: sensor ticks in, results out.
// Predicts each tick's result in place and checks it field by field. Depends on ecc_pkg.
module tb_environment_climate_controller;

  typedef struct {
    logic [9:0]  temp;
    logic [9:0]  light;
    logic [9:0]  gas;
    logic [15:0] hum;
  } tick_t;

  typedef struct {
    logic       heater;
    logic [3:0] bars;
    logic [9:0] duty;
    logic       air_bad;
    logic       alarm;
    logic       led;
    logic [8:0] degrees;
    logic [6:0] percent;
  } climate_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [9:0]         temp_sample = '0;
  logic [9:0]         light_sample = '0;
  logic [9:0]         gas_sample = '0;
  logic [15:0]        hum_raw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               heater_on;
  logic [3:0]         light_bars;
  logic [9:0]         fan_duty;
  logic               air_bad;
  logic               alarm_active;
  logic               alarm_led;
  logic [8:0]         temp_degrees;
  logic [6:0]         hum_percent;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ecc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [9:0]         cfg_data = '0;

  environment_climate_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .temp_sample(temp_sample), .light_sample(light_sample),
    .gas_sample(gas_sample), .hum_raw(hum_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .heater_on(heater_on), .light_bars(light_bars), .fan_duty(fan_duty),
    .air_bad(air_bad), .alarm_active(alarm_active), .alarm_led(alarm_led),
    .temp_degrees(temp_degrees), .hum_percent(hum_percent),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted controller state and settings
  ecc_pkg::cfg_t settings;
  logic          heater_st;
  logic [7:0]    gas_cnt;
  logic          alarm_st;
  logic          blink_st;

  climate_t expected_q[$];

  // Stimulus shaping
  bit          quiet = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          gas_bad_phase = 1'b0;
  int unsigned gas_run_left = 0;

  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned alarm_results = 0;
  int unsigned heater_results = 0;
  int unsigned held_cycles = 0;
  int unsigned error_count = 0;

  function automatic climate_t predict_climate(tick_t tk);
    climate_t    r;
    int unsigned deg, pct, hraw, duty;
    deg  = 32'(tk.temp) * 500 / 1023;
    hraw = 32'(tk.hum);
    if (hraw == 0 || hraw == 32'hFFFF) pct = 40;
    else pct = hraw * 100 / 65535;

    if (deg < 32'(settings.heat_on_below)) heater_st = 1'b1;
    else if (deg > 32'(settings.heat_off_above)) heater_st = 1'b0;

    r.bars = '0;
    for (int k = 0; k < 4; k++) begin
      if (int'(tk.light) < (4 - k) * int'(settings.light_step)) r.bars[k] = 1'b1;
    end

    r.air_bad = (tk.gas > settings.gas_limit);
    if (r.air_bad) begin
      duty = 1023;
      if (gas_cnt < settings.gas_delay_ticks) gas_cnt = gas_cnt + 8'd1;
      else alarm_st = 1'b1;
    end else begin
      gas_cnt  = '0;
      alarm_st = 1'b0;
      if (pct > 32'(settings.hum_full)) duty = 1023;
      else if (pct > 32'(settings.hum_ramp_start)) begin
        duty = (pct - 32'(settings.hum_ramp_start)) * 341;
        if (duty > 1023) duty = 1023;
      end else duty = 0;
    end

    r.led     = alarm_st & blink_st;
    blink_st  = ~blink_st;
    r.heater  = heater_st;
    r.duty    = duty[9:0];
    r.alarm   = alarm_st;
    r.degrees = deg[8:0];
    r.percent = pct[6:0];
    return r;
  endfunction

  function automatic logic [9:0] temp_for(int unsigned deg);
    int unsigned t;
    t = (deg * 1023 + 499) / 500;
    return (t > 1023) ? 10'd1023 : t[9:0];
  endfunction

  // Smallest raw word that reads as the given percent; 0 percent needs a nonzero word
  function automatic logic [15:0] hum_for(int unsigned pct);
    int unsigned h;
    if (pct > 99) pct = 99;
    h = (pct == 0) ? 1 : (pct * 65535 + 99) / 100;
    return h[15:0];
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic send_tick(input logic [9:0] t, input logic [9:0] l, input logic [9:0] g,
                           input logic [15:0] h);
    tick_t       tk;
    int unsigned gap;
    gap = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    temp_sample  <= t;
    light_sample <= l;
    gas_sample   <= g;
    hum_raw      <= h;
    do @(posedge clk); while (in_stall);
    tk.temp  = t;
    tk.light = l;
    tk.gas   = g;
    tk.hum   = h;
    expected_q.push_back(predict_climate(tk));
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [ecc_pkg::CfgIdxW-1:0] idx, input int unsigned value);
    logic [9:0] data;
    data = value[9:0];
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ecc_pkg::REG_HEAT_ON_BELOW:   settings.heat_on_below   = data[8:0];
      ecc_pkg::REG_HEAT_OFF_ABOVE:  settings.heat_off_above  = data[8:0];
      ecc_pkg::REG_GAS_LIMIT:       settings.gas_limit       = data;
      ecc_pkg::REG_GAS_DELAY_TICKS: settings.gas_delay_ticks = data[7:0];
      ecc_pkg::REG_LIGHT_STEP:      settings.light_step      = data[7:0];
      ecc_pkg::REG_HUM_RAMP_START:  settings.hum_ramp_start  = data[6:0];
      ecc_pkg::REG_HUM_FULL:        settings.hum_full        = data[6:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the last offered item first so nothing is taken twice while draining
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned on_below, input int unsigned off_above,
                                input int unsigned limit, input int unsigned delay,
                                input int unsigned step, input int unsigned ramp_start,
                                input int unsigned full);
    wait_idle();
    write_reg(ecc_pkg::REG_HEAT_ON_BELOW, on_below);
    write_reg(ecc_pkg::REG_HEAT_OFF_ABOVE, off_above);
    write_reg(ecc_pkg::REG_GAS_LIMIT, limit);
    write_reg(ecc_pkg::REG_GAS_DELAY_TICKS, delay);
    write_reg(ecc_pkg::REG_LIGHT_STEP, step);
    write_reg(ecc_pkg::REG_HUM_RAMP_START, ramp_start);
    write_reg(ecc_pkg::REG_HUM_FULL, full);
  endtask

  task automatic apply_defaults();
    apply_settings(32'(ecc_pkg::HEAT_ON_BELOW_RST), 32'(ecc_pkg::HEAT_OFF_ABOVE_RST),
                   32'(ecc_pkg::GAS_LIMIT_RST), 32'(ecc_pkg::GAS_DELAY_TICKS_RST),
                   32'(ecc_pkg::LIGHT_STEP_RST), 32'(ecc_pkg::HUM_RAMP_START_RST),
                   32'(ecc_pkg::HUM_FULL_RST));
  endtask

  // Often readings near the current thresholds, with bad-air runs long enough to alarm
  function automatic tick_t gen_tick();
    tick_t       tk;
    int unsigned lo, hi, d, p;
    int          v;
    if ($urandom_range(0, 1) == 0) begin
      lo = (settings.heat_on_below < settings.heat_off_above) ?
           32'(settings.heat_on_below) : 32'(settings.heat_off_above);
      hi = (settings.heat_on_below < settings.heat_off_above) ?
           32'(settings.heat_off_above) : 32'(settings.heat_on_below);
      lo = (lo > 3) ? lo - 3 : 0;
      hi = hi + 3;
      if (lo > 500) lo = 500;
      if (hi > 500) hi = 500;
      d = $urandom_range(lo, hi);
      tk.temp = temp_for(d) + 10'($urandom_range(0, 1));
      if (tk.temp == 10'd0 && d == 500) tk.temp = 10'd1023;
    end else tk.temp = 10'($urandom_range(0, 1023));

    if ($urandom_range(0, 1) == 0) begin
      v = int'($urandom_range(1, 4)) * int'(settings.light_step)
          + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      tk.light = v[9:0];
    end else tk.light = 10'($urandom_range(0, 1023));

    case ($urandom_range(0, 19))
      0: tk.hum = 16'h0000;
      1: tk.hum = 16'hFFFF;
      2: tk.hum = 16'h0001;
      3: tk.hum = 16'hFFFE;
      4, 5, 6, 7, 8, 9, 10, 11, 12: begin
        lo = (settings.hum_ramp_start > 7'd2) ? 32'(settings.hum_ramp_start) - 2 : 0;
        hi = 32'(settings.hum_full) + 3;
        if (lo > hi) begin
          p  = lo;
          lo = hi;
          hi = p;
        end
        if (hi > 99) hi = 99;
        if (lo > 99) lo = 99;
        tk.hum = hum_for($urandom_range(lo, hi));
      end
      default: tk.hum = 16'($urandom_range(0, 65535));
    endcase

    if (gas_run_left == 0) begin
      gas_bad_phase = ~gas_bad_phase;
      gas_run_left  = gas_bad_phase ? $urandom_range(1, 32'(settings.gas_delay_ticks) + 4)
                                    : $urandom_range(1, 6);
    end
    gas_run_left--;
    if ($urandom_range(0, 9) == 0) tk.gas = 10'($urandom_range(0, 1023));
    else if (gas_bad_phase && settings.gas_limit < 10'd1023)
      tk.gas = 10'($urandom_range(32'(settings.gas_limit) + 1, 1023));
    else if (!gas_bad_phase) tk.gas = 10'($urandom_range(0, 32'(settings.gas_limit)));
    else tk.gas = 10'd1023;
    return tk;
  endfunction

  task automatic send_random(input int unsigned count);
    tick_t tk;
    repeat (count) begin
      tk = gen_tick();
      send_tick(tk.temp, tk.light, tk.gas, tk.hum);
    end
  endtask

  task automatic test_sensor_extremes();
    apply_defaults();
    send_tick(10'd0, 10'd0, 10'd0, 16'h0000);
    send_tick(10'd1023, 10'd1023, 10'd1023, 16'hFFFF);
    send_tick(10'd1, 10'd199, 10'd400, 16'h0001);
    send_tick(10'd1022, 10'd200, 10'd401, 16'hFFFE);
    send_tick(10'd500, 10'd800, 10'd0, hum_for(48));
  endtask

  task automatic test_heater_band();
    apply_defaults();
    send_tick(temp_for(36), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(34), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(36), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(37), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(38), 10'd500, 10'd0, hum_for(30));
    // on threshold above off threshold: the on test wins
    apply_settings(40, 30, 32'(ecc_pkg::GAS_LIMIT_RST), 32'(ecc_pkg::GAS_DELAY_TICKS_RST),
                   32'(ecc_pkg::LIGHT_STEP_RST), 32'(ecc_pkg::HUM_RAMP_START_RST),
                   32'(ecc_pkg::HUM_FULL_RST));
    send_tick(temp_for(35), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(45), 10'd500, 10'd0, hum_for(30));
    send_tick(temp_for(35), 10'd500, 10'd0, hum_for(30));
  endtask

  task automatic test_gas_alarm();
    // zero delay raises the alarm on the first bad tick; the lamp follows the blink phase
    apply_settings(32'(ecc_pkg::HEAT_ON_BELOW_RST), 32'(ecc_pkg::HEAT_OFF_ABOVE_RST), 1022, 0,
                   32'(ecc_pkg::LIGHT_STEP_RST), 32'(ecc_pkg::HUM_RAMP_START_RST),
                   32'(ecc_pkg::HUM_FULL_RST));
    send_tick(10'd100, 10'd300, 10'd1023, hum_for(50));
    send_tick(10'd100, 10'd300, 10'd1023, hum_for(50));
    send_tick(10'd100, 10'd300, 10'd1022, hum_for(50));
    send_tick(10'd100, 10'd300, 10'd1023, hum_for(50));
  endtask

  task automatic test_fan_ramp();
    apply_settings(32'(ecc_pkg::HEAT_ON_BELOW_RST), 32'(ecc_pkg::HEAT_OFF_ABOVE_RST),
                   32'(ecc_pkg::GAS_LIMIT_RST), 32'(ecc_pkg::GAS_DELAY_TICKS_RST),
                   32'(ecc_pkg::LIGHT_STEP_RST), 0, 100);
    send_tick(10'd200, 10'd600, 10'd0, hum_for(1));
    send_tick(10'd200, 10'd600, 10'd0, hum_for(3));
    send_tick(10'd200, 10'd600, 10'd0, hum_for(4));
    send_tick(10'd200, 10'd600, 10'd0, 16'h0000);
  endtask

  task automatic test_light_bars();
    apply_settings(32'(ecc_pkg::HEAT_ON_BELOW_RST), 32'(ecc_pkg::HEAT_OFF_ABOVE_RST),
                   32'(ecc_pkg::GAS_LIMIT_RST), 32'(ecc_pkg::GAS_DELAY_TICKS_RST),
                   0, 32'(ecc_pkg::HUM_RAMP_START_RST), 32'(ecc_pkg::HUM_FULL_RST));
    send_tick(10'd300, 10'd0, 10'd0, hum_for(20));
    apply_settings(32'(ecc_pkg::HEAT_ON_BELOW_RST), 32'(ecc_pkg::HEAT_OFF_ABOVE_RST),
                   32'(ecc_pkg::GAS_LIMIT_RST), 32'(ecc_pkg::GAS_DELAY_TICKS_RST),
                   255, 32'(ecc_pkg::HUM_RAMP_START_RST), 32'(ecc_pkg::HUM_FULL_RST));
    send_tick(10'd300, 10'd254, 10'd0, hum_for(20));
    send_tick(10'd300, 10'd1019, 10'd0, hum_for(20));
    send_tick(10'd300, 10'd1020, 10'd0, hum_for(20));
  endtask

  task automatic test_output_backpressure();
    apply_defaults();
    quiet     = 1'b1;
    hold_left = 64;
    send_random(24);
    quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: apply_defaults();
        1: apply_settings(0, 0, 0, 0, 1, 0, 0);
        2: apply_settings(511, 511, 1023, 255, 255, 127, 127);
        3: apply_settings(60, 20, 700, 3, 90, 70, 60);
        default: apply_settings($urandom_range(0, 500), $urandom_range(0, 500),
                                $urandom_range(0, 1023), $urandom_range(0, 40),
                                $urandom_range(1, 255), $urandom_range(0, 100),
                                $urandom_range(0, 100));
      endcase
      send_random(200);
      // a stretch with no idling on either side
      quiet = 1'b1;
      send_random(60);
      quiet = 1'b0;
      send_random(140);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    climate_t want;
    if (!rst) begin
      if (in_valid && in_stall) held_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with no tick pending");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("heater_on", 32'(want.heater), 32'(heater_on));
          check_field("light_bars", 32'(want.bars), 32'(light_bars));
          check_field("fan_duty", 32'(want.duty), 32'(fan_duty));
          check_field("air_bad", 32'(want.air_bad), 32'(air_bad));
          check_field("alarm_active", 32'(want.alarm), 32'(alarm_active));
          check_field("alarm_led", 32'(want.led), 32'(alarm_led));
          check_field("temp_degrees", 32'(want.degrees), 32'(temp_degrees));
          check_field("hum_percent", 32'(want.percent), 32'(hum_percent));
          results_checked++;
          if (want.alarm) alarm_results++;
          if (want.heater) heater_results++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned drain;
    settings.heat_on_below   = ecc_pkg::HEAT_ON_BELOW_RST;
    settings.heat_off_above  = ecc_pkg::HEAT_OFF_ABOVE_RST;
    settings.gas_limit       = ecc_pkg::GAS_LIMIT_RST;
    settings.gas_delay_ticks = ecc_pkg::GAS_DELAY_TICKS_RST;
    settings.light_step      = ecc_pkg::LIGHT_STEP_RST;
    settings.hum_ramp_start  = ecc_pkg::HUM_RAMP_START_RST;
    settings.hum_full        = ecc_pkg::HUM_FULL_RST;
    heater_st = 1'b0;
    gas_cnt   = '0;
    alarm_st  = 1'b0;
    blink_st  = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sensor_extremes();
    test_heater_band();
    test_gas_alarm();
    test_fan_ramp();
    test_light_bars();
    test_output_backpressure();
    test_random_phases();

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b1;
    drain = 0;
    while (expected_q.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      error_count++;
    end

    $display("Sent %0d ticks, checked %0d results, made %0d register writes",
             ticks_sent, results_checked, cfg_writes);
    $display("Alarm up on %0d results, heater on for %0d; input held off %0d cycles",
             alarm_results, heater_results, held_cycles);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
